// ----- src/rsb_pkg.sv -----
// Shared types, constants and helper functions of the rank/select bit vector.
package rsb_pkg;

  localparam int unsigned WORD_COUNT = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned VAL_W      = 18;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned WIDX_W     = 13;
  localparam int unsigned SBW_W      = 6;
  localparam int unsigned REM_W      = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MAX_LEN    = WORD_COUNT * WORD_BITS;
  localparam int unsigned MAX_SBW    = 32;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SBW    = 2'd1;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_BUILD = 3'd1,
    OP_RANK  = 3'd2,
    OP_SEL1  = 3'd3,
    OP_SEL0  = 3'd4,
    OP_NEXT  = 3'd5,
    OP_PREV  = 3'd6,
    OP_NOP   = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_WR,
    ST_BUILD_REQ,
    ST_BUILD_USE,
    ST_DIV,
    ST_RANK_CNT_REQ,
    ST_RANK_CNT_USE,
    ST_SEL_REQ,
    ST_SEL_USE,
    ST_WRD_REQ,
    ST_WRD_USE,
    ST_BIT,
    ST_DONE
  } st_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] word_address;
    logic [31:0]       write_data;
    logic [VAL_W-1:0]  query_value;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0]  leff;
    logic [SBW_W-1:0]  seff;
    logic [WIDX_W-1:0] nw;
  } cfg_t;

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < 32; i++) c = c + 6'(v[i]);
    return c;
  endfunction

  function automatic logic [31:0] low_mask(input logic [4:0] n);
    logic [32:0] m;
    m = (33'd1 << n) - 33'd1;
    return m[31:0];
  endfunction

  function automatic logic [4:0] lowest_bit(input logic [31:0] v);
    logic [4:0] b;
    b = '0;
    for (int i = 31; i >= 0; i--) if (v[i]) b = 5'(i);
    return b;
  endfunction

  function automatic logic [4:0] highest_bit(input logic [31:0] v);
    logic [4:0] b;
    b = '0;
    for (int i = 0; i < 32; i++) if (v[i]) b = 5'(i);
    return b;
  endfunction

endpackage

// ----- src/rsb_if.sv -----
// Valid/ready channel interfaces for items, results and configuration writes.
interface rsb_in_if;
  import rsb_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [ADDR_W-1:0] word_address;
  logic [31:0]       write_data;
  logic [VAL_W-1:0]  query_value;
  modport source (output valid, op, word_address, write_data, query_value, input ready);
  modport sink (input valid, op, word_address, write_data, query_value, output ready);
endinterface

interface rsb_out_if;
  import rsb_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] result_value;
  logic             not_found;
  modport source (output valid, result_value, not_found, input ready);
  modport sink (input valid, result_value, not_found, output ready);
endinterface

interface rsb_cfg_if;
  import rsb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/bitvector_rank_select.sv -----
// Top level of the rank/select bit vector: configuration registers and the two halves.
//
// Items enter on in_i (op, word_address, write_data, query_value) and each
// produces exactly one result on out_o (result_value, not_found), in order.
// Configuration writes arrive on cfg_i: index 0 sets length_bits, index 1
// sets superblock_words; cfg_i is always ready, and the user must see that it is
// written only while idle; the block does not enforce this. A two-entry queue
// takes items while the engine works; the engine runs one item at a time.
// Steps per item: build reads every word and writes one count per superblock;
// rank waits for the divider, reads its superblock count, then scans words up
// to the position within its superblock; select scans the count table, then
// words from the chosen superblock, then the bits of the final word; next
// and previous scan words. Results sit in an output register; a stalled receiver
// holds the engine in its final step while the queue keeps accepting items.
// Reset restores the register defaults (131072 bits, 16 words per superblock)
// and empties the queue; the word store and count table are not cleared.
module bitvector_rank_select (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsb_in_if.sink    in_i,
  rsb_cfg_if.sink   cfg_i,
  rsb_out_if.source out_o
);
  import rsb_pkg::*;

  logic [VAL_W-1:0] len_q, len_d;
  logic [SBW_W-1:0] sbw_q, sbw_d;
  cfg_t             cfg;
  item_t            item;
  logic             item_valid, item_ready;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    len_d = len_q;
    sbw_d = sbw_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LENGTH: len_d = cfg_i.data;
        CFG_SBW:    sbw_d = cfg_i.data[SBW_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= VAL_W'(MAX_LEN);
      sbw_q <= SBW_W'(16);
    end else begin
      len_q <= len_d;
      sbw_q <= sbw_d;
    end
  end

  always_comb begin
    if (len_q == '0) begin
      cfg.leff = VAL_W'(1);
    end else if (len_q > VAL_W'(MAX_LEN)) begin
      cfg.leff = VAL_W'(MAX_LEN);
    end else begin
      cfg.leff = len_q;
    end
    if (sbw_q == '0) begin
      cfg.seff = SBW_W'(1);
    end else if (sbw_q > SBW_W'(MAX_SBW)) begin
      cfg.seff = SBW_W'(MAX_SBW);
    end else begin
      cfg.seff = sbw_q;
    end
    cfg.nw = WIDX_W'(((VAL_W + 1)'(cfg.leff) + (VAL_W + 1)'(31)) >> 5);
  end

  rsb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  rsb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .cfg_i        (cfg),
    .out_o        (out_o)
  );
endmodule

// ----- src/rsb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/rsb_front.sv -----
// Front end: accepts items, decodes the operation and queues them for the engine.
module rsb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rsb_in_if.sink         in_i,
  output rsb_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);
  import rsb_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t             mem_q [FIFO_DEPTH];
  item_t             in_item;
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign in_i.ready   = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rptr_q];
  assign push         = in_i.valid && in_i.ready;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    in_item.op           = op_e'(in_i.op);
    in_item.word_address = in_i.word_address;
    in_item.write_data   = in_i.write_data;
    in_item.query_value  = in_i.query_value;
  end

  always_comb begin
    wptr_d = push ? PTR_W'(wptr_q + 1'b1) : wptr_q;
    rptr_d = pop ? PTR_W'(rptr_q + 1'b1) : rptr_q;
    cnt_d  = CNT_W'(cnt_q + CNT_W'(push) - CNT_W'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_item;
    end
  end
endmodule

// ----- src/rsb_div.sv -----
// Restoring divider, one quotient bit per cycle, for the superblock index of rank.
module rsb_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsb_pkg::WIDX_W-1:0] dividend_i,
  input  logic [rsb_pkg::SBW_W-1:0]  divisor_i,
  output logic [rsb_pkg::WIDX_W-1:0] quot_o,
  output logic [rsb_pkg::SBW_W-1:0]  rem_o,
  output logic                       done_o
);
  import rsb_pkg::*;

  localparam int unsigned STEP_W = $clog2(WIDX_W + 1);

  logic [WIDX_W-1:0] quot_q, quot_d;
  logic [SBW_W-1:0]  rem_q, rem_d, div_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [SBW_W:0]    trial, diff;
  logic              ge;

  assign trial  = {rem_q, quot_q[WIDX_W-1]};
  assign ge     = (trial >= {1'b0, div_q});
  assign diff   = trial - {1'b0, div_q};
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = STEP_W'(WIDX_W);
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quot_d = {quot_q[WIDX_W-2:0], ge};
      rem_d  = ge ? diff[SBW_W-1:0] : trial[SBW_W-1:0];
      step_d = STEP_W'(step_q - 1'b1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end
endmodule

// ----- src/rsb_back.sv -----
// Back end: sequencer that runs one item against the word store and count table.
module rsb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rsb_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  rsb_pkg::cfg_t  cfg_i,
  rsb_out_if.source      out_o
);
  import rsb_pkg::*;

  st_e                     state_q, state_d;
  op_e                     op_q, op_d;
  logic [VAL_W-1:0]        qv_q, qv_d;
  logic [WIDX_W-1:0]       cur_w_q, cur_w_d, endw_q, endw_d, tb_q, tb_d, sb_q, sb_d;
  logic [SBW_W-1:0]        sbcnt_q, sbcnt_d;
  logic [VAL_W-1:0]        acc_q, acc_d, bits_q, bits_d;
  logic signed [REM_W-1:0] rem_q, rem_d;
  logic [31:0]             word_q, word_d;
  logic [4:0]              bit_q, bit_d, part_q, part_d;
  logic                    first_q, first_d;
  logic [VAL_W-1:0]        res_q, res_d, out_res_q;
  logic                    nf_q, nf_d, out_nf_q, out_valid_q, out_valid_d;

  logic [31:0]             word_rdata, vm, wa, tv, nv, pv;
  logic [VAL_W-1:0]        cnt_rdata;
  logic                    word_we, cnt_we, div_start, div_done;
  logic [WIDX_W-1:0]       div_quot;
  logic [SBW_W-1:0]        div_rem;
  logic [5:0]              c;
  logic signed [REM_W-1:0] c_s, seen_cnt, k_s;
  logic [VAL_W:0]          q1, q;
  logic [VAL_W-1:0]        pp;
  logic [23:0]             bits_sum;
  logic [WIDX_W-1:0]       tb_next, cur_w_inc;
  logic                    out_free, start, sel_take, sel_cont, sel_hit, last_w;
  logic                    rank_more, rank_cont, bit_set, bit_match;

  rsb_ram #(.WIDTH(32), .DEPTH(WORD_COUNT)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (item_i.word_address),
    .wdata_i (item_i.write_data),
    .raddr_i (cur_w_q[ADDR_W-1:0]),
    .rdata_o (word_rdata)
  );

  rsb_ram #(.WIDTH(VAL_W), .DEPTH(WORD_COUNT + 1)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (sb_q),
    .wdata_i (acc_q),
    .raddr_i (sb_q),
    .rdata_o (cnt_rdata)
  );

  rsb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (q[VAL_W-1:5]),
    .divisor_i  (cfg_i.seff),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  assign item_ready_o   = (state_q == ST_IDLE);
  assign start          = item_valid_i && item_ready_o;
  assign out_free       = !out_valid_q || out_o.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.not_found    = out_nf_q;

  always_comb begin
    if (cur_w_q >= cfg_i.nw) begin
      vm = '0;
    end else if (cur_w_q == WIDX_W'(cfg_i.nw - 1'b1) && cfg_i.leff[4:0] != '0) begin
      vm = low_mask(cfg_i.leff[4:0]);
    end else begin
      vm = '1;
    end
  end

  assign wa        = word_rdata & vm;
  assign tv        = (op_q == OP_SEL1) ? wa : (~word_rdata & vm);
  assign nv        = first_q ? (wa & ~low_mask(part_q)) : wa;
  assign pv        = first_q ? (wa & (low_mask(part_q) | (32'd1 << part_q))) : wa;
  assign c         = (op_q == OP_RANK && !rank_more) ? pop32(wa & low_mask(part_q))
                   : (op_q == OP_RANK) ? pop32(wa) : pop32(tv);
  assign c_s       = $signed(REM_W'(c));
  assign k_s       = $signed(REM_W'(qv_q));
  assign seen_cnt  = (op_q == OP_SEL1) ? $signed(REM_W'(cnt_rdata))
                   : $signed(REM_W'(bits_q)) - $signed(REM_W'(cnt_rdata));
  assign sel_take  = (sb_q == '0) || (seen_cnt < k_s);
  assign bits_sum  = 24'(bits_q) + 24'({cfg_i.seff, 5'b0});
  assign tb_next   = WIDX_W'(tb_q + WIDX_W'(cfg_i.seff));
  assign sel_cont  = (tb_next < cfg_i.nw);
  assign sel_hit   = (c_s >= rem_q);
  assign cur_w_inc = WIDX_W'(cur_w_q + 1'b1);
  assign last_w    = (cur_w_inc >= cfg_i.nw);
  assign rank_more = (cur_w_q < endw_q);
  assign rank_cont = (cur_w_inc < endw_q) || (part_q != '0);
  assign bit_set   = word_q[bit_q];
  assign bit_match = bit_set && (rem_q == REM_W'(1));
  assign q1        = (VAL_W + 1)'(item_i.query_value) + 1'b1;
  assign q         = (q1 > (VAL_W + 1)'(cfg_i.leff)) ? (VAL_W + 1)'(cfg_i.leff) : q1;
  assign pp        = (item_i.query_value >= cfg_i.leff) ? VAL_W'(cfg_i.leff - 1'b1)
                   : item_i.query_value;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (item_i.op)
            OP_BUILD: state_d = ST_BUILD_WR;
            OP_RANK:  state_d = ST_DIV;
            OP_SEL1, OP_SEL0: begin
              state_d = (item_i.query_value == '0) ? ST_DONE : ST_SEL_REQ;
            end
            OP_NEXT: begin
              state_d = (item_i.query_value >= cfg_i.leff) ? ST_DONE : ST_WRD_REQ;
            end
            OP_PREV: state_d = ST_WRD_REQ;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_BUILD_WR:     state_d = (cur_w_q < cfg_i.nw) ? ST_BUILD_REQ : ST_DONE;
      ST_BUILD_REQ:    state_d = ST_BUILD_USE;
      ST_BUILD_USE:    state_d = (sbcnt_q == SBW_W'(1)) ? ST_BUILD_WR : ST_BUILD_REQ;
      ST_DIV:          state_d = div_done ? ST_RANK_CNT_REQ : ST_DIV;
      ST_RANK_CNT_REQ: state_d = ST_RANK_CNT_USE;
      ST_RANK_CNT_USE: state_d = (rank_more || part_q != '0) ? ST_WRD_REQ : ST_DONE;
      ST_SEL_REQ:      state_d = ST_SEL_USE;
      ST_SEL_USE:      state_d = sel_cont ? ST_SEL_REQ : ST_WRD_REQ;
      ST_WRD_REQ:      state_d = ST_WRD_USE;
      ST_WRD_USE: begin
        case (op_q)
          OP_RANK:          state_d = (rank_more && rank_cont) ? ST_WRD_REQ : ST_DONE;
          OP_SEL1, OP_SEL0: state_d = sel_hit ? ST_BIT : (last_w ? ST_DONE : ST_WRD_REQ);
          OP_NEXT:          state_d = (nv != '0 || last_w) ? ST_DONE : ST_WRD_REQ;
          OP_PREV:          state_d = (pv != '0 || cur_w_q == '0) ? ST_DONE : ST_WRD_REQ;
          default:          state_d = ST_DONE;
        endcase
      end
      ST_BIT:  state_d = (bit_match || bit_q == 5'd31) ? ST_DONE : ST_BIT;
      ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    qv_d        = qv_q;
    cur_w_d     = cur_w_q;
    endw_d      = endw_q;
    tb_d        = tb_q;
    sb_d        = sb_q;
    sbcnt_d     = sbcnt_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    rem_d       = rem_q;
    word_d      = word_q;
    bit_d       = bit_q;
    part_d      = part_q;
    first_d     = first_q;
    res_d       = res_q;
    nf_d        = nf_q;
    out_valid_d = out_valid_q && !out_o.ready;
    word_we     = 1'b0;
    cnt_we      = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = item_i.op;
          qv_d    = item_i.query_value;
          res_d   = '0;
          nf_d    = 1'b0;
          first_d = 1'b1;
          case (item_i.op)
            OP_WRITE: word_we = 1'b1;
            OP_BUILD: begin
              acc_d   = '0;
              sb_d    = '0;
              cur_w_d = '0;
            end
            OP_RANK: begin
              div_start = 1'b1;
              endw_d    = q[VAL_W-1:5];
              part_d    = q[4:0];
            end
            OP_SEL1, OP_SEL0: begin
              sb_d   = '0;
              tb_d   = '0;
              bits_d = '0;
              if (item_i.query_value == '0) begin
                res_d = cfg_i.leff;
                nf_d  = 1'b1;
              end
            end
            OP_NEXT: begin
              cur_w_d = item_i.query_value[VAL_W-1:5];
              part_d  = item_i.query_value[4:0];
              if (item_i.query_value >= cfg_i.leff) begin
                res_d = cfg_i.leff;
                nf_d  = 1'b1;
              end
            end
            OP_PREV: begin
              cur_w_d = pp[VAL_W-1:5];
              part_d  = pp[4:0];
            end
            default: ;
          endcase
        end
      end
      ST_BUILD_WR: begin
        cnt_we  = 1'b1;
        sb_d    = WIDX_W'(sb_q + 1'b1);
        sbcnt_d = cfg_i.seff;
      end
      ST_BUILD_USE: begin
        acc_d   = VAL_W'(acc_q + VAL_W'(pop32(wa)));
        cur_w_d = cur_w_inc;
        sbcnt_d = SBW_W'(sbcnt_q - 1'b1);
      end
      ST_DIV: begin
        if (div_done) begin
          sb_d    = div_quot;
          cur_w_d = WIDX_W'(endw_q - WIDX_W'(div_rem));
        end
      end
      ST_RANK_CNT_USE: begin
        acc_d = cnt_rdata;
        res_d = cnt_rdata;
      end
      ST_SEL_USE: begin
        if (sel_take) begin
          cur_w_d = tb_q;
          rem_d   = k_s - seen_cnt;
        end
        tb_d   = tb_next;
        sb_d   = WIDX_W'(sb_q + 1'b1);
        bits_d = (bits_sum > 24'(cfg_i.leff)) ? cfg_i.leff : VAL_W'(bits_sum);
      end
      ST_WRD_USE: begin
        first_d = 1'b0;
        case (op_q)
          OP_RANK: begin
            acc_d = VAL_W'(acc_q + VAL_W'(c));
            res_d = VAL_W'(acc_q + VAL_W'(c));
            if (rank_more) begin
              cur_w_d = cur_w_inc;
            end
          end
          OP_SEL1, OP_SEL0: begin
            if (sel_hit) begin
              word_d = tv;
              bit_d  = '0;
            end else begin
              rem_d = rem_q - c_s;
              if (last_w) begin
                res_d = cfg_i.leff;
                nf_d  = 1'b1;
              end else begin
                cur_w_d = cur_w_inc;
              end
            end
          end
          OP_NEXT: begin
            if (nv != '0) begin
              res_d = {cur_w_q, lowest_bit(nv)};
            end else if (last_w) begin
              res_d = cfg_i.leff;
              nf_d  = 1'b1;
            end else begin
              cur_w_d = cur_w_inc;
            end
          end
          OP_PREV: begin
            if (pv != '0) begin
              res_d = {cur_w_q, highest_bit(pv)};
            end else if (cur_w_q == '0) begin
              res_d = cfg_i.leff;
              nf_d  = 1'b1;
            end else begin
              cur_w_d = WIDX_W'(cur_w_q - 1'b1);
            end
          end
          default: ;
        endcase
      end
      ST_BIT: begin
        if (bit_match) begin
          res_d = {cur_w_q, bit_q};
        end else begin
          if (bit_set) begin
            rem_d = rem_q - REM_W'(1);
          end
          if (bit_q == 5'd31) begin
            res_d = cfg_i.leff;
            nf_d  = 1'b1;
          end
          bit_d = 5'(bit_q + 1'b1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    qv_q    <= qv_d;
    cur_w_q <= cur_w_d;
    endw_q  <= endw_d;
    tb_q    <= tb_d;
    sb_q    <= sb_d;
    sbcnt_q <= sbcnt_d;
    acc_q   <= acc_d;
    bits_q  <= bits_d;
    rem_q   <= rem_d;
    word_q  <= word_d;
    bit_q   <= bit_d;
    part_q  <= part_d;
    first_q <= first_d;
    res_q   <= res_d;
    nf_q    <= nf_d;
    if (state_q == ST_DONE && out_free) begin
      out_res_q <= res_q;
      out_nf_q  <= nf_q;
    end
  end

`ifndef SYNTH
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q)
    else $error("finished result was not presented");
  a_word_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRD_REQ) |-> (cur_w_q < cfg_i.nw))
    else $error("word scan left the vector");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q != ST_IDLE))
    else $error("accepted item did not start");
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_RANK_CNT_REQ))
    else $error("bad exit from divide wait");
`endif
endmodule

// ----- tb/sv/bitvector_rank_select_chk.sv -----
// Checker that mirrors the rank/select bit vector and compares every result transfer.
module bitvector_rank_select_chk
  import rsb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rsb_in_if         in_m,
  rsb_cfg_if        cfg_m,
  rsb_out_if        out_m,
  output int        mismatches_o,
  output int        results_seen_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             missing;
  } answer_t;

  logic [31:0]      bits_mem [WORD_COUNT];
  logic [VAL_W-1:0] sb_ones  [WORD_COUNT+1];
  logic [VAL_W-1:0] len_reg;
  logic [SBW_W-1:0] sbw_reg;
  answer_t          answers_q [$];

  function automatic longint eff_len();
    longint l;
    l = (len_reg == 0) ? 1 : longint'(len_reg);
    if (l > MAX_LEN) l = MAX_LEN;
    return l;
  endfunction

  function automatic longint eff_sbw();
    longint s;
    s = (sbw_reg == 0) ? 1 : longint'(sbw_reg);
    if (s > MAX_SBW) s = MAX_SBW;
    return s;
  endfunction

  function automatic longint n_words();
    return (eff_len() + 31) / 32;
  endfunction

  function automatic longint n_sblocks();
    return (n_words() + eff_sbw() - 1) / eff_sbw();
  endfunction

  function automatic longint live_bits(longint w);
    longint l;
    l = eff_len();
    if (w >= n_words()) return 0;
    if (l - w * 32 >= 32) return 32;
    return l - w * 32;
  endfunction

  function automatic logic [31:0] lo_bits(longint n);
    if (n >= 32) return 32'hFFFF_FFFF;
    return ~(32'hFFFF_FFFF << n);
  endfunction

  function automatic logic [31:0] masked_word(longint w);
    longint vb;
    vb = live_bits(w);
    if (vb == 0) return '0;
    return bits_mem[w] & lo_bits(vb);
  endfunction

  function automatic void rebuild_counts();
    longint nsb, s, c;
    nsb = n_sblocks();
    s = eff_sbw();
    sb_ones[0] = '0;
    for (longint j = 1; j <= nsb && j <= WORD_COUNT; j++) begin
      c = sb_ones[j-1];
      for (longint w = (j - 1) * s; w < j * s; w++) c += $countones(masked_word(w));
      sb_ones[j] = VAL_W'(c);
    end
  endfunction

  function automatic longint ones_upto(longint p);
    longint l, s, q, sb, r;
    l = eff_len();
    s = eff_sbw();
    q = p + 1;
    if (q > l) q = l;
    sb = q / (s * 32);
    if (sb > WORD_COUNT) sb = WORD_COUNT;
    r = sb_ones[sb];
    for (longint w = sb * s; w < q / 32; w++) r += $countones(masked_word(w));
    if (q % 32 != 0) r += $countones(masked_word(q / 32) & lo_bits(q % 32));
    return r;
  endfunction

  function automatic longint zeros_before(longint t, longint s, longint l);
    longint b;
    b = t * s * 32;
    if (b > l) b = l;
    return b - longint'(sb_ones[t]);
  endfunction

  function automatic bit find_kth(longint k, bit ones, output longint pos);
    longint nsb, s, l, nw, j, rem, seen, c, vb;
    logic [31:0] v;
    nsb = n_sblocks();
    s = eff_sbw();
    l = eff_len();
    nw = n_words();
    j = 0;
    pos = 0;
    if (k == 0) return 0;
    for (longint t = 0; t < nsb && t <= WORD_COUNT; t++) begin
      seen = ones ? longint'(sb_ones[t]) : zeros_before(t, s, l);
      if (seen < k) j = t;
    end
    rem = k - (ones ? longint'(sb_ones[j]) : zeros_before(j, s, l));
    for (longint w = j * s; w < nw; w++) begin
      v = masked_word(w);
      vb = live_bits(w);
      c = ones ? $countones(v) : vb - $countones(v);
      if (c >= rem) begin
        for (longint b = 0; b < vb; b++) begin
          if (v[b] == ones) begin
            rem--;
            if (rem == 0) begin
              pos = w * 32 + b;
              return 1;
            end
          end
        end
        return 0;
      end
      rem -= c;
    end
    return 0;
  endfunction

  function automatic bit one_at_or_after(longint p, output longint pos);
    longint w, nw;
    logic [31:0] v;
    pos = 0;
    nw = n_words();
    if (p >= eff_len()) return 0;
    w = p / 32;
    v = masked_word(w) & ~lo_bits(p % 32);
    forever begin
      if (v != 0) begin
        for (int b = 0; b < 32; b++) if (v[b]) begin
          pos = w * 32 + b;
          return 1;
        end
      end
      w++;
      if (w >= nw) return 0;
      v = masked_word(w);
    end
  endfunction

  function automatic bit one_at_or_before(longint p, output longint pos);
    longint w, l;
    logic [31:0] v;
    pos = 0;
    l = eff_len();
    if (p >= l) p = l - 1;
    w = p / 32;
    v = masked_word(w) & lo_bits(p % 32 + 1);
    forever begin
      if (v != 0) begin
        for (int b = 31; b >= 0; b--) if (v[b]) begin
          pos = w * 32 + b;
          return 1;
        end
      end
      if (w == 0) return 0;
      w--;
      v = masked_word(w);
    end
  endfunction

  function automatic answer_t predict(op_e op, logic [ADDR_W-1:0] addr, logic [31:0] data,
                                      logic [VAL_W-1:0] qv);
    answer_t a;
    longint pos;
    bit hit;
    a = '0;
    hit = 1;
    pos = 0;
    case (op)
      OP_WRITE: bits_mem[addr] = data;
      OP_BUILD: rebuild_counts();
      OP_RANK:  a.value = VAL_W'(ones_upto(qv));
      OP_SEL1:  hit = find_kth(qv, 1'b1, pos);
      OP_SEL0:  hit = find_kth(qv, 1'b0, pos);
      OP_NEXT:  hit = one_at_or_after(qv, pos);
      OP_PREV:  hit = one_at_or_before(qv, pos);
      default: ;
    endcase
    if (op inside {OP_SEL1, OP_SEL0, OP_NEXT, OP_PREV}) begin
      a.value   = hit ? VAL_W'(pos) : VAL_W'(eff_len());
      a.missing = !hit;
    end
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      len_reg <= VAL_W'(MAX_LEN);
      sbw_reg <= SBW_W'(16);
      answers_q.delete();
      mismatches_o   <= 0;
      results_seen_o <= 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        results_seen_o <= results_seen_o + 1;
        if (answers_q.size() == 0) begin
          $error("unexpected result transfer: result_value %0d not_found %0d",
                 out_m.result_value, out_m.not_found);
          mismatches_o <= mismatches_o + 1;
        end else begin
          exp_a = answers_q.pop_front();
          if (out_m.result_value !== exp_a.value || out_m.not_found !== exp_a.missing)
            mismatches_o <= mismatches_o + 1;
          if (out_m.result_value !== exp_a.value)
            $error("result_value: expected %0d, got %0d", exp_a.value, out_m.result_value);
          if (out_m.not_found !== exp_a.missing)
            $error("not_found: expected %0d, got %0d", exp_a.missing, out_m.not_found);
        end
      end
      if (in_m.valid && in_m.ready)
        answers_q.push_back(predict(op_e'(in_m.op), in_m.word_address, in_m.write_data,
                                    in_m.query_value));
      if (cfg_m.valid && cfg_m.ready) begin
        if (cfg_m.index == CFG_LENGTH) len_reg <= cfg_m.data;
        else if (cfg_m.index == CFG_SBW) sbw_reg <= SBW_W'(cfg_m.data);
      end
    end
  end

  assign pending_o = answers_q.size();

endmodule

// ----- tb/sv/bitvector_rank_select_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the rank/select bit vector.
module bitvector_rank_select_tb;
  import rsb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIR_WORDS = 128;
  localparam int DIR_LEN   = DIR_WORDS * 32;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   results_seen;
  int   pending;
  int   items_sent;
  int   cur_len;

  rsb_in_if  in_if ();
  rsb_cfg_if cfg_if ();
  rsb_out_if out_if ();

  bitvector_rank_select dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  bitvector_rank_select_chk chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_m          (in_if),
    .cfg_m         (cfg_if),
    .out_m         (out_if),
    .mismatches_o  (mismatches),
    .results_seen_o(results_seen),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(op_e op, int addr, logic [31:0] data, int qv);
    int g;
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.op           <= op;
    in_if.word_address <= ADDR_W'(addr);
    in_if.write_data   <= data;
    in_if.query_value  <= VAL_W'(qv);
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= VAL_W'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] word_pattern();
    case ($urandom_range(0, 5))
      0, 1: return '0;
      2: return 32'hFFFF_FFFF;
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, cur_len + 1);
    if (r == 7) return $urandom_range(0, 262143);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return cur_len - 1;
      default: return cur_len;
    endcase
  endfunction

  task automatic random_item();
    int r, nw;
    r = $urandom_range(0, 99);
    nw = (cur_len + 31) / 32;
    if (r < 25) begin
      send(OP_WRITE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, nw - 1),
           word_pattern(), $urandom_range(0, 262143));
    end else if (r < 30) begin
      send(OP_BUILD, $urandom_range(0, 4095), $urandom(), $urandom_range(0, 262143));
    end else if (r < 97) begin
      case ($urandom_range(0, 4))
        0: send(OP_RANK, $urandom_range(0, 4095), $urandom(), pick_pos());
        1: send(OP_SEL1, $urandom_range(0, 4095), $urandom(),
                ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : pick_pos());
        2: send(OP_SEL0, $urandom_range(0, 4095), $urandom(),
                ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : pick_pos());
        3: send(OP_NEXT, $urandom_range(0, 4095), $urandom(), pick_pos());
        default: send(OP_PREV, $urandom_range(0, 4095), $urandom(), pick_pos());
      endcase
    end else begin
      send(OP_NOP, $urandom_range(0, 4095), $urandom(), $urandom_range(0, 262143));
    end
  endtask

  task automatic run_phase(int len, int sbw, int n);
    int eff;
    drain();
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_SBW, sbw);
    eff = (len == 0) ? 1 : len;
    cur_len = (eff > MAX_LEN) ? MAX_LEN : eff;
    send(OP_BUILD, 0, '0, 0);
    repeat (n) random_item();
  endtask

  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        out_if.ready <= 1'b1;
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_NOP;
    in_if.word_address = '0;
    in_if.write_data = '0;
    in_if.query_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_LENGTH;
    cfg_if.data = '0;
    items_sent = 0;
    cur_len = MAX_LEN;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_LENGTH, DIR_LEN);
    write_reg(CFG_SBW, 16);
    cur_len = DIR_LEN;
    for (int w = 0; w < DIR_WORDS; w++) send(OP_WRITE, w, word_pattern(), 0);
    send(OP_BUILD, 0, '0, 0);
    send(OP_RANK, 0, '0, 0);
    send(OP_RANK, 0, '0, MAX_LEN - 1);
    send(OP_RANK, 0, '0, 262143);
    send(OP_SEL1, 0, '0, 0);
    send(OP_SEL1, 0, '0, 1);
    send(OP_SEL1, 0, '0, 262143);
    send(OP_SEL0, 0, '0, 0);
    send(OP_SEL0, 0, '0, 1);
    send(OP_SEL0, 0, '0, 262143);
    send(OP_NEXT, 0, '0, 0);
    send(OP_NEXT, 0, '0, MAX_LEN);
    send(OP_NEXT, 0, '0, 262143);
    send(OP_PREV, 0, '0, 0);
    send(OP_PREV, 0, '0, 262143);
    send(OP_NOP, 4095, 32'hFFFF_FFFF, 262143);
    send(OP_WRITE, DIR_WORDS - 1, 32'h8000_0000, 0);
    send(OP_NEXT, 0, '0, DIR_LEN - 32);
    send(OP_RANK, 0, '0, MAX_LEN);

    drain();
    write_reg(CFG_LENGTH, 1);
    write_reg(CFG_SBW, 1);
    cur_len = 1;
    send(OP_WRITE, 0, 32'hFFFF_FFFE, 0);
    send(OP_BUILD, 0, '0, 0);
    send(OP_PREV, 0, '0, 0);
    send(OP_NEXT, 0, '0, 0);
    send(OP_SEL1, 0, '0, 1);
    send(OP_SEL0, 0, '0, 1);
    send(OP_RANK, 0, '0, 5);

    run_phase(DIR_LEN, 16, 60);
    run_phase(0, 0, 60);
    run_phase(DIR_LEN - 1, 63, 60);
    run_phase(33, 32, 100);
    run_phase(100, 3, 100);
    run_phase(777, 5, 100);
    run_phase(4000, 32, 100);
    run_phase(300, 17, 100);
    run_phase(2500, 2, 100);
    run_phase(64, 1, 100);
    run_phase(2049, 0, 40);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
